FILE: rtl/core/hrluf_pkg.sv
package hrluf_pkg;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_SEEK_SP = 4'd1,
        PH_SKIP1   = 4'd2,
        PH_PAGE    = 4'd3,
        PH_SKIP2   = 4'd4,
        PH_PROTO   = 4'd5,
        PH_MAJOR   = 4'd6,
        PH_MINOR   = 4'd7,
        PH_DONE_OK = 4'd8,
        PH_FAIL    = 4'd9
    } phase_t;

    localparam logic [1:0] METHOD_UNKNOWN = 2'd0;
    localparam logic [1:0] METHOD_GET     = 2'd1;
    localparam logic [1:0] METHOD_POST    = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_G_LO  = 8'h67;
    localparam logic [7:0] CH_G_UP  = 8'h47;
    localparam logic [7:0] CH_P_LO  = 8'h70;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned PAGE_LIMIT_W = 10;
    localparam logic [PAGE_LIMIT_W-1:0] PAGE_LIMIT_RESET = 10'd1022;

    localparam int unsigned VER_W = 16;
    localparam logic [2:0] PATTERN_LEN = 3'd7;
    localparam logic [2:0] PROTO_LAST = 3'd4;

    // forbidden text "images/"
    function automatic logic [7:0] pattern_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h69;
            3'd1: c = 8'h6D;
            3'd2: c = 8'h61;
            3'd3: c = 8'h67;
            3'd4: c = 8'h65;
            3'd5: c = 8'h73;
            3'd6: c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // acc * 10 + d, saturated
    function automatic logic [VER_W-1:0] add_digit(input logic [VER_W-1:0] acc,
                                                  input logic [3:0] d);
        logic [VER_W+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VER_W{1'b0}}, d};
        return (v > {4'd0, {VER_W{1'b1}}}) ? {VER_W{1'b1}} : v[VER_W-1:0];
    endfunction

endpackage

FILE: rtl/core/http_request_line_url_filter_core.sv
// channel   | signals                                        | dir
// ----------+------------------------------------------------+-----
// s_ (byte) | s_valid s_ready s_line_byte s_line_end         | in
// m_ (line) | m_valid m_ready m_parse_ok m_method_kind       | out
//           | m_version_major m_version_minor m_page_length  |
//           | m_deny                                         |
// cfg       | cfg_valid cfg_ready cfg_page_limit             | in
//
// one byte per cycle, but for the line-end stall below: a byte is held in the input register, the parser
// state update runs from there, and the line result lands in the output register
// reset (aresetn low, synchronous) clears the parser and sets page_limit to 1022
// a line-end byte waits in the input register only while a result is held and
// not taken; other bytes never wait on the result side
module http_request_line_url_filter_core
    import hrluf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_line_byte,
    input  logic                    s_line_end,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_parse_ok,
    output logic [1:0]              m_method_kind,
    output logic [VER_W-1:0]        m_version_major,
    output logic [VER_W-1:0]        m_version_minor,
    output logic [PAGE_LIMIT_W-1:0] m_page_length,
    output logic                    m_deny,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [PAGE_LIMIT_W-1:0] cfg_page_limit
);

    logic [PAGE_LIMIT_W-1:0] page_limit_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    phase_t                  phase_reg, phase_next, phase_upd;
    logic [PAGE_LIMIT_W-1:0] count_reg, count_next, count_upd;
    logic [2:0]              proto_reg, proto_next, proto_upd;
    logic [2:0]              match_reg, match_next, match_upd;
    logic                    found_reg, found_next, found_upd;
    logic [1:0]              method_reg, method_next, method_upd;
    logic [VER_W-1:0]        major_reg, major_next, major_upd;
    logic [VER_W-1:0]        minor_reg, minor_next, minor_upd;

    logic                    out_valid_reg, out_valid_next;
    logic                    ok_reg;
    logic [1:0]              kind_reg;
    logic [VER_W-1:0]        vmaj_reg, vmin_reg;
    logic [PAGE_LIMIT_W-1:0] len_reg;
    logic                    deny_reg;

    logic       out_free, step, load_out, result_ok, page_take, is_digit;
    logic [7:0] c;

    assign c         = in_byte_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && (!in_end_reg || out_free);
    assign load_out  = step && in_end_reg;
    assign s_ready   = !in_valid_reg || step;
    assign cfg_ready = 1'b1;
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);

    // page byte handling, shared by the first-skip and page phases
    assign page_take = (c != CH_SPACE) && (c != CH_NUL) && (count_reg < page_limit_reg);

    always_comb begin
        phase_upd  = phase_reg;
        count_upd  = count_reg;
        proto_upd  = proto_reg;
        match_upd  = match_reg;
        found_upd  = found_reg;
        method_upd = method_reg;
        major_upd  = major_reg;
        minor_upd  = minor_reg;

        case (phase_reg)
            PH_METHOD: begin
                if (c == CH_G_LO || c == CH_G_UP) begin
                    method_upd = METHOD_GET;
                    phase_upd  = PH_SEEK_SP;
                end else if (c == CH_P_LO || c == CH_P_UP) begin
                    method_upd = METHOD_POST;
                    phase_upd  = PH_SEEK_SP;
                end else begin
                    method_upd = METHOD_UNKNOWN;
                    phase_upd  = PH_FAIL;
                end
            end
            PH_SEEK_SP: begin
                if (c == CH_SPACE)
                    phase_upd = PH_SKIP1;
                else if (c == CH_NUL)
                    phase_upd = PH_FAIL;
            end
            PH_SKIP1, PH_PAGE: begin
                if (c == CH_SPACE) begin
                    if (phase_reg == PH_PAGE)
                        phase_upd = PH_SKIP2;
                end else if (page_take) begin
                    phase_upd = PH_PAGE;
                    count_upd = count_reg + 1'b1;
                    if (!found_reg) begin
                        if (c == pattern_char(match_reg)) begin
                            match_upd = match_reg + 1'b1;
                            if (match_reg == PATTERN_LEN - 3'd1)
                                found_upd = 1'b1;
                        end else begin
                            match_upd = (c == pattern_char(3'd0)) ? 3'd1 : 3'd0;
                        end
                    end
                end else begin
                    phase_upd = PH_FAIL;
                end
            end
            PH_SKIP2: begin
                if (c == CH_H) begin
                    proto_upd = 3'd1;
                    phase_upd = PH_PROTO;
                end else if (c != CH_SPACE) begin
                    phase_upd = PH_FAIL;
                end
            end
            PH_PROTO: begin
                if (proto_reg < PROTO_LAST) begin
                    if (c == CH_NUL)
                        phase_upd = PH_FAIL;
                    else
                        proto_upd = proto_reg + 1'b1;
                end else begin
                    phase_upd = (c == CH_SLASH) ? PH_MAJOR : PH_FAIL;
                end
            end
            PH_MAJOR: begin
                if (is_digit)
                    major_upd = add_digit(major_reg, c[3:0]);
                else if (c == CH_DOT)
                    phase_upd = PH_MINOR;
                else
                    phase_upd = PH_FAIL;
            end
            PH_MINOR: begin
                if (is_digit)
                    minor_upd = add_digit(minor_reg, c[3:0]);
                else
                    phase_upd = PH_DONE_OK;
            end
            default: begin
            end
        endcase
    end

    assign result_ok = (phase_upd == PH_MINOR) || (phase_upd == PH_DONE_OK);

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        proto_next  = proto_reg;
        match_next  = match_reg;
        found_next  = found_reg;
        method_next = method_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        if (step) begin
            if (in_end_reg) begin
                // line done: start the next one clean
                phase_next  = PH_METHOD;
                count_next  = '0;
                proto_next  = '0;
                match_next  = '0;
                found_next  = 1'b0;
                method_next = METHOD_UNKNOWN;
                major_next  = '0;
                minor_next  = '0;
            end else begin
                phase_next  = phase_upd;
                count_next  = count_upd;
                proto_next  = proto_upd;
                match_next  = match_upd;
                found_next  = found_upd;
                method_next = method_upd;
                major_next  = major_upd;
                minor_next  = minor_upd;
            end
        end
    end

    always_comb begin
        if (s_valid && s_ready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (load_out)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg <= PAGE_LIMIT_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_METHOD;
            count_reg      <= '0;
            proto_reg      <= '0;
            match_reg      <= '0;
            found_reg      <= 1'b0;
            method_reg     <= METHOD_UNKNOWN;
            major_reg      <= '0;
            minor_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready)
                page_limit_reg <= cfg_page_limit;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            proto_reg     <= proto_next;
            match_reg     <= match_next;
            found_reg     <= found_next;
            method_reg    <= method_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_line_byte;
            in_end_reg  <= s_line_end;
        end
        if (load_out) begin
            ok_reg   <= result_ok;
            kind_reg <= method_upd;
            vmaj_reg <= result_ok ? major_upd : '0;
            vmin_reg <= result_ok ? minor_upd : '0;
            len_reg  <= count_upd;
            deny_reg <= found_upd;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_parse_ok      = ok_reg;
    assign m_method_kind   = kind_reg;
    assign m_version_major = vmaj_reg;
    assign m_version_minor = vmin_reg;
    assign m_page_length   = len_reg;
    assign m_deny          = deny_reg;

endmodule
